// File: design/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
// Used by rbd_ctrl, ring_buffer_deque and the testbench; depends on nothing.
package rbd_pkg;

    // Fixed field widths of the command and result ports
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int OFF_W  = 4;
    localparam int STAT_W = 2;

    // Default geometry handed to the top level
    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    // Operation selector; codes six and seven are ignored
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_READ       = 3'd4,
        FN_CLEAR      = 3'd5
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Result control passed from the controller to the top level
    typedef struct packed {
        logic    strobe;
        logic    take;
        t_status status;
    } t_resp;

endpackage

// File: design/rbd_mem.sv
// Entry store for the ring buffer deque: one write port, one registered read port.
// Depends on nothing outside this file.
module rbd_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data; it is held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rbd_ctrl.sv
// Pointer, count and status logic of the ring buffer deque.
// Depends on rbd_pkg for the operation, status and result types.
module rbd_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [rbd_pkg::FUNC_W-1:0] i_func,
    input  logic [rbd_pkg::OFF_W-1:0]  i_offset,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output rbd_pkg::t_resp             o_resp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OFF_W = rbd_pkg::OFF_W;
    localparam int SUM_W = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;
    localparam int CMP_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;

    logic [PTR_W-1:0] r_front, n_front;
    logic [PTR_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;
    rbd_pkg::t_resp   r_resp,  n_resp;

    logic             full, empty;
    logic [SUM_W-1:0] rd_sum, rd_wrap;

    // Step a pointer forward with wrap at the store depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Step a pointer back with wrap at the store depth
    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Front plus offset stays below twice the depth when the read is in range
    assign rd_sum  = SUM_W'(r_front) + SUM_W'(i_offset);
    assign rd_wrap = (rd_sum >= SUM_W'(DEPTH)) ? rd_sum - SUM_W'(DEPTH) : rd_sum;

    // Decode the operation and work out the next pointers, count and status
    always_comb begin
        n_front       = r_front;
        n_back        = r_back;
        n_count       = r_count;
        o_we          = 1'b0;
        o_waddr       = r_front;
        o_re          = 1'b0;
        o_raddr       = r_front;
        n_resp.strobe = i_accept;
        n_resp.take   = 1'b0;
        n_resp.status = rbd_pkg::ST_OK;
        if (i_accept) begin
            case (rbd_pkg::t_func'(i_func))
                rbd_pkg::FN_PUSH_FRONT: begin
                    if (full) begin
                        n_resp.status = rbd_pkg::ST_FULL;
                    end else begin
                        n_front = ptr_dec(r_front);
                        if (empty) begin
                            n_back = n_front;
                        end
                        o_we    = 1'b1;
                        o_waddr = n_front;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                rbd_pkg::FN_PUSH_BACK: begin
                    if (full) begin
                        n_resp.status = rbd_pkg::ST_FULL;
                    end else begin
                        n_back = ptr_inc(r_back);
                        if (empty) begin
                            n_front = n_back;
                        end
                        o_we    = 1'b1;
                        o_waddr = n_back;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                rbd_pkg::FN_POP_FRONT: begin
                    if (empty) begin
                        n_resp.status = rbd_pkg::ST_EMPTY;
                    end else begin
                        o_re        = 1'b1;
                        o_raddr     = r_front;
                        n_resp.take = 1'b1;
                        n_front     = ptr_inc(r_front);
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                rbd_pkg::FN_POP_BACK: begin
                    if (empty) begin
                        n_resp.status = rbd_pkg::ST_EMPTY;
                    end else begin
                        o_re        = 1'b1;
                        o_raddr     = r_back;
                        n_resp.take = 1'b1;
                        n_back      = ptr_dec(r_back);
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                rbd_pkg::FN_READ: begin
                    if (empty) begin
                        n_resp.status = rbd_pkg::ST_EMPTY;
                    end else if (CMP_W'(i_offset) >= CMP_W'(r_count)) begin
                        n_resp.status = rbd_pkg::ST_RANGE;
                    end else begin
                        o_re        = 1'b1;
                        o_raddr     = rd_wrap[PTR_W-1:0];
                        n_resp.take = 1'b1;
                    end
                end
                rbd_pkg::FN_CLEAR: begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end
                default: begin
                    // unused selectors: leave everything as it is
                end
            endcase
        end
    end

    // Hold pointers, count and the result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_resp  <= '0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_resp  <= n_resp;
        end
    end

    assign o_count = r_count;
    assign o_resp  = r_resp;

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // A write is only issued with room left and grows the count by one
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |=> (r_count == $past(r_count) + CNT_W'(1)) && ($past(r_count) < CNT_W'(DEPTH)))
        else $error("write issued on a full store or count not advanced");

    // A taken value always comes from a read of a non-empty store
    a_take_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_resp.take |-> o_re && !empty && !o_we)
        else $error("value taken without a valid read");

endmodule

// File: design/ring_buffer_deque.sv
// Top level of the ring buffer deque: command port, controller and entry store.
// Depends on rbd_pkg, rbd_ctrl and rbd_mem.
//
// A command is transferred at each rising edge with start high and busy low; busy
// is held low, so a command may be issued in every cycle. Its result appears on
// o_value_out, o_fill_count and o_status one cycle later, for exactly one cycle,
// marked by o_strobe, and must be taken then: there is no way to hold it off.
// The value is held in the registered read port of the entry store, and
// throughput is one command per cycle. The store is not cleared at reset; only
// entries that were pushed are ever returned. Failed commands change nothing and
// return zero with status empty, full or offset out of range.
module ring_buffer_deque #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEF,
    parameter int WIDTH = rbd_pkg::WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rbd_pkg::FUNC_W-1:0] i_func,
    input  logic [rbd_pkg::DATA_W-1:0] i_push_value,
    input  logic [rbd_pkg::OFF_W-1:0]  i_offset,
    output logic                       o_strobe,
    output logic [rbd_pkg::DATA_W-1:0] o_value_out,
    output logic [$clog2(DEPTH+1)-1:0] o_fill_count,
    output logic [rbd_pkg::STAT_W-1:0] o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DW    = rbd_pkg::DATA_W;

    logic             accept;
    logic             mem_we, mem_re;
    logic [PTR_W-1:0] mem_waddr, mem_raddr;
    logic [WIDTH-1:0] mem_wdata, mem_rdata;
    rbd_pkg::t_resp   resp;

    // Every command is taken on the cycle it is issued
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Keep the low bits of the pushed data that fit an entry
    assign mem_wdata = WIDTH'(i_push_value);

    rbd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (i_func),
        .i_offset (i_offset),
        .o_we     (mem_we),
        .o_waddr  (mem_waddr),
        .o_re     (mem_re),
        .o_raddr  (mem_raddr),
        .o_count  (o_fill_count),
        .o_resp   (resp)
    );

    rbd_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Drive the result; drop the read data unless this transfer took an entry
    assign o_strobe    = resp.strobe;
    assign o_status    = resp.status;
    assign o_value_out = resp.take ? DW'(mem_rdata) : '0;

    // Each accepted command gives exactly one strobe on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("accepted command gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result strobe without a command");

    // A full status is only reported at capacity, an empty one only at zero
    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && ((o_status == rbd_pkg::ST_FULL && o_fill_count != CNT_W'(DEPTH)) ||
                     (o_status == rbd_pkg::ST_EMPTY && o_fill_count != '0)) |-> 1'b0)
        else $error("status disagrees with fill count");

endmodule

// File: tb/tb_ring_buffer_deque.sv
// Self-checking testbench for the ring buffer deque: directed table, then random episodes.
// Depends on rbd_pkg and ring_buffer_deque; results are checked against a local deque model or typed table rows.
module tb_ring_buffer_deque;

    localparam int FUNC_W      = rbd_pkg::FUNC_W;
    localparam int DATA_W      = rbd_pkg::DATA_W;
    localparam int OFF_W       = rbd_pkg::OFF_W;
    localparam int STAT_W      = rbd_pkg::STAT_W;
    localparam int DEPTH       = rbd_pkg::DEPTH_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STALL_LIMIT = 200;
    localparam int PHASE_ITEMS = 175;
    localparam int PRINT_CAP   = 50;

    // Selector codes the block ignores
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

    // Episode shapes for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
        rbd_pkg::t_status  status;
    } t_deque_result;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;
        logic [OFF_W-1:0]  off;
        bit                typed;
        t_deque_result     res;
    } t_smoke_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [DATA_W-1:0]   i_push_value;
    logic [OFF_W-1:0]    i_offset;
    logic                o_strobe;
    logic [DATA_W-1:0]   o_value_out;
    logic [CNT_W-1:0]    o_fill_count;
    logic [STAT_W-1:0]   o_status;

    // Typed expectation travelling with the command, used by the directed table
    logic                cmd_typed;
    t_deque_result       cmd_typed_exp;

    // Local deque model state
    logic [DATA_W-1:0]   dq_store [DEPTH];
    logic [OFF_W-1:0]    dq_front;
    logic [OFF_W-1:0]    dq_back;
    logic [CNT_W-1:0]    dq_count;

    t_deque_result       pending_results [$];
    int                  error_count = 0;
    int                  stall_cycles = 0;
    int                  shadow_count = 0;

    // Directed table: empty queue, extremes, pointer wrap, clear, push on empty
    t_smoke_row smoke_rows [23] = '{
        '{rbd_pkg::FN_POP_FRONT, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
        '{rbd_pkg::FN_POP_BACK, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
        '{rbd_pkg::FN_READ, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
        '{rbd_pkg::FN_READ, 32'h0, 4'd15, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
        '{FN_SPARE_A, 32'hFFFFFFFF, 4'd15, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{FN_SPARE_B, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_PUSH_BACK, 32'hFFFFFFFF, 4'd0, 1'b1, '{32'h0, 5'd1, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_PUSH_FRONT, 32'h0, 4'd15, 1'b1, '{32'h0, 5'd2, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_READ, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd2, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_READ, 32'h0, 4'd1, 1'b1, '{32'hFFFFFFFF, 5'd2, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_READ, 32'h0, 4'd2, 1'b1, '{32'h0, 5'd2, rbd_pkg::ST_RANGE}},
        '{rbd_pkg::FN_READ, 32'h0, 4'd15, 1'b1, '{32'h0, 5'd2, rbd_pkg::ST_RANGE}},
        '{rbd_pkg::FN_PUSH_FRONT, 32'hA5A5A5A5, 4'd0, 1'b0, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_PUSH_FRONT, 32'h5A5A5A5A, 4'd0, 1'b0, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_POP_BACK, 32'h0, 4'd0, 1'b0, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_POP_FRONT, 32'h0, 4'd0, 1'b0, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_CLEAR, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_POP_BACK, 32'h0, 4'd0, 1'b1, '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
        '{rbd_pkg::FN_PUSH_FRONT, 32'h12345678, 4'd0, 1'b1, '{32'h0, 5'd1, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_POP_BACK, 32'h0, 4'd0, 1'b1, '{32'h12345678, 5'd0, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_PUSH_BACK, 32'h87654321, 4'd0, 1'b1, '{32'h0, 5'd1, rbd_pkg::ST_OK}},
        '{rbd_pkg::FN_POP_FRONT, 32'h0, 4'd0, 1'b1, '{32'h87654321, 5'd0, rbd_pkg::ST_OK}},
        '{FN_SPARE_A, 32'h0, 4'd7, 1'b0, '{32'h0, 5'd0, rbd_pkg::ST_OK}}
    };

    ring_buffer_deque dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .i_offset     (i_offset),
        .o_strobe     (o_strobe),
        .o_value_out  (o_value_out),
        .o_fill_count (o_fill_count),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one operation to the local deque and return the result it gives
    function automatic t_deque_result apply_deque_op(logic [FUNC_W-1:0] fn,
                                                     logic [DATA_W-1:0] val,
                                                     logic [OFF_W-1:0]  off);
        t_deque_result r;
        logic [OFF_W-1:0] idx;
        r.value  = '0;
        r.status = rbd_pkg::ST_OK;
        idx      = dq_front + off;
        case (fn)
            rbd_pkg::FN_PUSH_FRONT, rbd_pkg::FN_PUSH_BACK: begin
                if (dq_count >= DEPTH) begin
                    r.status = rbd_pkg::ST_FULL;
                end else if (fn == rbd_pkg::FN_PUSH_FRONT) begin
                    dq_front = dq_front - 1'b1;
                    if (dq_count == 0) dq_back = dq_front;
                    dq_store[dq_front] = val;
                    dq_count = dq_count + 1'b1;
                end else begin
                    dq_back = dq_back + 1'b1;
                    if (dq_count == 0) dq_front = dq_back;
                    dq_store[dq_back] = val;
                    dq_count = dq_count + 1'b1;
                end
            end
            rbd_pkg::FN_POP_FRONT, rbd_pkg::FN_POP_BACK: begin
                if (dq_count == 0) begin
                    r.status = rbd_pkg::ST_EMPTY;
                end else if (fn == rbd_pkg::FN_POP_FRONT) begin
                    r.value  = dq_store[dq_front];
                    dq_front = dq_front + 1'b1;
                    dq_count = dq_count - 1'b1;
                end else begin
                    r.value  = dq_store[dq_back];
                    dq_back  = dq_back - 1'b1;
                    dq_count = dq_count - 1'b1;
                end
            end
            rbd_pkg::FN_READ: begin
                if (dq_count == 0) r.status = rbd_pkg::ST_EMPTY;
                else if (off >= dq_count) r.status = rbd_pkg::ST_RANGE;
                else r.value = dq_store[idx];
            end
            rbd_pkg::FN_CLEAR: begin
                dq_front = '0;
                dq_back  = '0;
                dq_count = '0;
            end
            default: ;
        endcase
        r.count = dq_count;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (error_count < PRINT_CAP)
            $display("mismatch %s: got %0h want %0h", field, got, want);
        error_count++;
    endtask

    // Predict on each command transfer, then check each result against the oldest one
    always @(posedge i_clk) begin : result_check
        t_deque_result pred;
        t_deque_result want;
        if (!i_rst_n) begin
            dq_front = '0;
            dq_back  = '0;
            dq_count = '0;
        end else begin
            if (start && !busy) begin
                pred = apply_deque_op(i_func, i_push_value, i_offset);
                pending_results.push_back(cmd_typed ? cmd_typed_exp : pred);
            end
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_value_out, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_value_out !== want.value)
                        report_mismatch("value", o_value_out, want.value);
                    if (o_fill_count !== want.count)
                        report_mismatch("fill count", DATA_W'(o_fill_count),
                                        DATA_W'(want.count));
                    if (o_status !== want.status)
                        report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                end
            end
        end
    end

    // Abort when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Present one command and hold it until the transfer edge
    task automatic issue(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
                         input logic [OFF_W-1:0] off, input bit typed,
                         input t_deque_result res);
        start         <= 1'b1;
        i_func        <= fn;
        i_push_value  <= val;
        i_offset      <= off;
        cmd_typed     <= typed;
        cmd_typed_exp <= res;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic maybe_idle(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has come back
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    // Draw one random command, shaped by the episode mode and the expected fill
    task automatic pick_cmd(input int mode, output logic [FUNC_W-1:0] fn,
                            output logic [DATA_W-1:0] val, output logic [OFF_W-1:0] off);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin push_lim = 90; pop_lim = 95; end
            MODE_DRAIN: begin push_lim = 8;  pop_lim = 90; end
            default:    begin push_lim = 35; pop_lim = 65; end
        endcase
        case ($urandom_range(9))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom();
        endcase
        off = OFF_W'($urandom_range(15));
        if (r < push_lim) begin
            fn = $urandom_range(1) ? rbd_pkg::FN_PUSH_BACK : rbd_pkg::FN_PUSH_FRONT;
        end else if (r < pop_lim) begin
            fn = $urandom_range(1) ? rbd_pkg::FN_POP_BACK : rbd_pkg::FN_POP_FRONT;
        end else if (mode != MODE_MIXED || r < 92) begin
            fn = rbd_pkg::FN_READ;
            // mostly in range, now and then anywhere
            if (shadow_count > 0 && $urandom_range(4) != 0)
                off = OFF_W'($urandom_range(shadow_count - 1));
        end else if (r < 95) begin
            fn = rbd_pkg::FN_CLEAR;
        end else begin
            fn = $urandom_range(1) ? FN_SPARE_B : FN_SPARE_A;
        end
        // advance the rough fill estimate used for read offsets
        if ((fn == rbd_pkg::FN_PUSH_FRONT || fn == rbd_pkg::FN_PUSH_BACK)
            && shadow_count < DEPTH)
            shadow_count++;
        else if ((fn == rbd_pkg::FN_POP_FRONT || fn == rbd_pkg::FN_POP_BACK)
                 && shadow_count > 0)
            shadow_count--;
        else if (fn == rbd_pkg::FN_CLEAR)
            shadow_count = 0;
    endtask

    initial begin
        int idle_pct [4] = '{0, 68, 0, 16};
        int items;
        int ep_len;
        int mode;
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;
        logic [OFF_W-1:0]  off;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_func        <= rbd_pkg::FN_CLEAR;
        i_push_value  <= '0;
        i_offset      <= '0;
        cmd_typed     <= 1'b0;
        cmd_typed_exp <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (smoke_rows[i]) begin
            issue(smoke_rows[i].fn, smoke_rows[i].val, smoke_rows[i].off,
                  smoke_rows[i].typed, smoke_rows[i].res);
            maybe_idle(25);
        end
        settle();

        // Random episodes: fill to full, drain to empty, or mixed traffic
        for (int phase = 0; phase < 4; phase++) begin
            items = 0;
            while (items < PHASE_ITEMS) begin
                if (phase == 0 && items == 0) begin
                    mode   = MODE_FILL;
                    ep_len = 30;
                end else begin
                    mode   = $urandom_range(MODE_MIXED);
                    ep_len = $urandom_range(8, 40);
                end
                for (int k = 0; k < ep_len && items < PHASE_ITEMS; k++) begin
                    pick_cmd(mode, fn, val, off);
                    issue(fn, val, off, 1'b0, '0);
                    items++;
                    maybe_idle(idle_pct[phase]);
                end
            end
            settle();
        end

        // Let any stray result surface before the verdict
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
design/rbd_pkg.sv
design/rbd_mem.sv
design/rbd_ctrl.sv
design/ring_buffer_deque.sv
tb/tb_ring_buffer_deque.sv
